// ===== design/crtt_pkg.sv =====
// Shared types and codes for the command retry timeout tracker.
`default_nettype none

package crtt_pkg;

    localparam int unsigned SeqW    = 32;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned RetryW  = 4;
    localparam int unsigned StatW   = 8;
    localparam int unsigned MaskW   = 2;
    localparam int unsigned CfgAddrW = 1;
    localparam int unsigned CfgDataW = 32;

    localparam logic [TimeW-1:0]  TIMEOUT_RESET = 32'd1000;
    localparam logic [RetryW-1:0] RETRIES_RESET = 4'd3;
    localparam logic [SeqW-1:0]   SEQ_FIRST     = 32'd1;

    localparam logic [MaskW-1:0] MASK_HOT  = 2'b01;
    localparam logic [MaskW-1:0] MASK_COLD = 2'b10;

    localparam logic [CfgAddrW-1:0] REG_TIMEOUT = 1'd0;
    localparam logic [CfgAddrW-1:0] REG_RETRIES = 1'd1;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_TICK = 2'd1,
        CMD_ACK  = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_SENT    = 4'd1,
        EV_BUSY    = 4'd2,
        EV_STAMP   = 4'd3,
        EV_RESEND  = 4'd4,
        EV_FAILED  = 4'd5,
        EV_ACK_OK  = 4'd6,
        EV_ACK_ERR = 4'd7,
        EV_ACK_IGN = 4'd8
    } t_event;

    typedef struct packed {
        logic [1:0]       cmd;
        logic             hot_on;
        logic             cold_on;
        logic [TimeW-1:0] now_ms;
        logic [SeqW-1:0]  ack_seq;
        logic [StatW-1:0] ack_status;
    } t_item;

    typedef struct packed {
        t_event            event_res;
        logic [MaskW-1:0]  relay_mask;
        logic [SeqW-1:0]   seq_out;
        logic [RetryW-1:0] retry_no;
        logic              pending;
    } t_result;

    typedef struct packed {
        logic                we;
        logic [CfgAddrW-1:0] addr;
        logic [CfgDataW-1:0] wdata;
    } t_cfg_wr;

endpackage

`default_nettype wire

// ===== design/crtt_in_reg.sv =====
// Input register stage: holds one accepted item until the core takes it.
`default_nettype none

module crtt_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire crtt_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_take,
    output crtt_pkg::t_item     o_item
);

    logic            r_valid;
    crtt_pkg::t_item r_item;

    // Refill in the same cycle the held item moves on.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/crtt_core.sv =====
// Tracker state, configuration registers and per-item event logic.
`default_nettype none

module crtt_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire crtt_pkg::t_cfg_wr i_cfg,
    input  wire logic             i_fire,
    input  wire crtt_pkg::t_item  i_item,
    output crtt_pkg::t_result     o_result
);

    logic [crtt_pkg::TimeW-1:0]  r_timeout_ms;
    logic [crtt_pkg::RetryW-1:0] r_max_retries;

    logic                        r_busy;
    logic [crtt_pkg::SeqW-1:0]   r_pending_seq;
    logic [crtt_pkg::TimeW-1:0]  r_stamp_time;
    logic [crtt_pkg::RetryW-1:0] r_retry_count;
    logic [crtt_pkg::SeqW-1:0]   r_next_seq;

    logic                        n_busy;
    logic [crtt_pkg::SeqW-1:0]   n_pending_seq;
    logic [crtt_pkg::TimeW-1:0]  n_stamp_time;
    logic [crtt_pkg::RetryW-1:0] n_retry_count;
    logic [crtt_pkg::SeqW-1:0]   n_next_seq;

    logic [crtt_pkg::TimeW-1:0]  elapsed;
    logic                        seq_from_ack;
    crtt_pkg::t_event            ev;
    logic [crtt_pkg::MaskW-1:0]  mask;

    assign elapsed = i_item.now_ms - r_stamp_time;

    always_comb begin
        n_busy        = r_busy;
        n_pending_seq = r_pending_seq;
        n_stamp_time  = r_stamp_time;
        n_retry_count = r_retry_count;
        n_next_seq    = r_next_seq;
        ev            = crtt_pkg::EV_NONE;
        mask          = '0;
        seq_from_ack  = 1'b0;
        unique case (i_item.cmd)
            crtt_pkg::CMD_SEND: begin
                if (r_busy) begin
                    ev = crtt_pkg::EV_BUSY;
                end else begin
                    mask = (i_item.hot_on  ? crtt_pkg::MASK_HOT  : '0)
                         | (i_item.cold_on ? crtt_pkg::MASK_COLD : '0);
                    n_busy        = 1'b1;
                    n_pending_seq = r_next_seq;
                    n_stamp_time  = '0;
                    n_retry_count = '0;
                    n_next_seq    = r_next_seq + 1'b1;
                    ev            = crtt_pkg::EV_SENT;
                end
            end
            crtt_pkg::CMD_TICK: begin
                // A stored time of zero means the send is not stamped yet.
                if (r_busy) begin
                    if (r_stamp_time == '0) begin
                        n_stamp_time = i_item.now_ms;
                        ev           = crtt_pkg::EV_STAMP;
                    end else if (elapsed >= r_timeout_ms) begin
                        if (r_retry_count >= r_max_retries) begin
                            n_busy = 1'b0;
                            ev     = crtt_pkg::EV_FAILED;
                        end else begin
                            n_retry_count = r_retry_count + 1'b1;
                            n_stamp_time  = i_item.now_ms;
                            ev            = crtt_pkg::EV_RESEND;
                        end
                    end
                end
            end
            crtt_pkg::CMD_ACK: begin
                if (!r_busy || i_item.ack_seq != r_pending_seq) begin
                    ev           = crtt_pkg::EV_ACK_IGN;
                    seq_from_ack = 1'b1;
                end else begin
                    n_busy = 1'b0;
                    ev     = (i_item.ack_status == '0) ? crtt_pkg::EV_ACK_OK
                                                        : crtt_pkg::EV_ACK_ERR;
                end
            end
            default: begin
                ev = crtt_pkg::EV_NONE;
            end
        endcase
    end

    always_comb begin
        o_result.event_res  = ev;
        o_result.relay_mask = mask;
        o_result.seq_out    = seq_from_ack ? i_item.ack_seq : n_pending_seq;
        o_result.retry_no   = n_retry_count;
        o_result.pending    = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms  <= crtt_pkg::TIMEOUT_RESET;
            r_max_retries <= crtt_pkg::RETRIES_RESET;
        end else if (i_cfg.we) begin
            unique case (i_cfg.addr)
                crtt_pkg::REG_TIMEOUT: r_timeout_ms  <= i_cfg.wdata;
                crtt_pkg::REG_RETRIES: r_max_retries <= i_cfg.wdata[crtt_pkg::RetryW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_pending_seq <= '0;
            r_stamp_time  <= '0;
            r_retry_count <= '0;
            r_next_seq    <= crtt_pkg::SEQ_FIRST;
        end else if (i_fire) begin
            r_busy        <= n_busy;
            r_pending_seq <= n_pending_seq;
            r_stamp_time  <= n_stamp_time;
            r_retry_count <= n_retry_count;
            r_next_seq    <= n_next_seq;
        end
    end

endmodule

`default_nettype wire

// ===== design/command_retry_timeout_tracker.sv =====
// Stop-and-wait command tracker top level: stream ports and result register.
//
// Usage: events (send, tick, acknowledgement) enter on the s_axis channel,
// with the event kind in s_axis_tuser. Every accepted item yields exactly one
// result on the m_axis channel, with the event code in m_axis_tuser.
// Path: an accepted item is held in the input register and is evaluated
// against the tracker state when the result register is free or being taken;
// that evaluation loads the result register, which offers it on m_axis.
// Throughput: one item per cycle while m_axis_tready stays high; the state
// update is combinational logic between the input and result registers.
// Stall: when m_axis_tready is low the result register holds, the input
// register takes one more item if it was empty, then s_axis_tready drops.
// Reset (i_rst_n low at a clock edge): both stages empty, the tracker goes
// idle with the next sequence number at 1, timeout 1000 ms, 3 retries.
// Configuration writes via i_cfg_we/i_cfg_addr/i_cfg_wdata take effect at
// once; write them only while no item is in flight.
`default_nettype none

module command_retry_timeout_tracker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // hot_on[0], cold_on[1], now_ms[33:2], ack_seq[65:34], ack_status[73:66]
    input  wire logic [79:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // relay_mask[1:0], seq_out[33:2], retry_no[37:34], pending[38]
    output logic [39:0]      m_axis_tdata,
    // event_res[3:0]
    output logic [3:0]       m_axis_tuser
);

    crtt_pkg::t_item   in_item;
    crtt_pkg::t_item   held_item;
    crtt_pkg::t_result result;
    crtt_pkg::t_cfg_wr cfg;
    logic              held_valid;
    logic              fire;

    logic              r_out_valid;
    crtt_pkg::t_result r_out;

    always_comb begin
        in_item.cmd        = s_axis_tuser;
        in_item.hot_on     = s_axis_tdata[0];
        in_item.cold_on    = s_axis_tdata[1];
        in_item.now_ms     = s_axis_tdata[33:2];
        in_item.ack_seq    = s_axis_tdata[65:34];
        in_item.ack_status = s_axis_tdata[73:66];
        cfg.we             = i_cfg_we;
        cfg.addr           = i_cfg_addr;
        cfg.wdata          = i_cfg_wdata;
    end

    // Evaluate the held item whenever the result register is free.
    assign fire = held_valid && (!r_out_valid || m_axis_tready);

    crtt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (fire),
        .o_item  (held_item)
    );

    crtt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.event_res;
    assign m_axis_tdata  = {1'b0, r_out.pending, r_out.retry_no, r_out.seq_out,
                            r_out.relay_mask};

endmodule

`default_nettype wire

// ===== verif/command_retry_timeout_tracker_test.sv =====
// Self-checking stream testbench for the command retry timeout tracker.
`timescale 1ns / 1ps

module command_retry_timeout_tracker_test;
    import crtt_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 165;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // hot_on[0], cold_on[1], now_ms[33:2], ack_seq[65:34], ack_status[73:66]
    logic [79:0] s_axis_tdata = '0;
    // cmd[1:0]
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // relay_mask[1:0], seq_out[33:2], retry_no[37:34], pending[38]
    logic [39:0] m_axis_tdata;
    // event_res[3:0]
    logic [3:0]  m_axis_tuser;

    command_retry_timeout_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Tracker mirror and its settings
    logic              trk_busy    = 1'b0;
    logic [SeqW-1:0]   trk_seq     = '0;
    logic [TimeW-1:0]  trk_stamp   = '0;
    logic [RetryW-1:0] trk_retries = '0;
    logic [SeqW-1:0]   trk_next    = SEQ_FIRST;
    logic [TimeW-1:0]  cfg_timeout = TIMEOUT_RESET;
    logic [RetryW-1:0] cfg_retries = RETRIES_RESET;

    t_result tracker_results_due[$];
    int      mismatch_cnt = 0;
    int      cycle_cnt = 0;
    logic    tx_gaps = 1'b1;
    logic    rx_stalls = 1'b1;
    logic    hold_req = 1'b0;
    logic [TimeW-1:0] wall_ms = '0;

    typedef struct {
        logic        is_cfg;
        logic [31:0] tmo;
        logic [3:0]  rty;
        t_item       it;
        logic        typed;
        t_result     want;
    } t_plan_row;

    t_plan_row plan[$];

    function automatic t_result advance_tracker(input t_item it);
        t_result          r;
        logic [TimeW-1:0] elapsed;
        r = '0;
        r.event_res = EV_NONE;
        case (it.cmd)
            CMD_SEND: begin
                if (trk_busy) begin
                    r.event_res = EV_BUSY;
                end else begin
                    r.relay_mask = (it.hot_on ? MASK_HOT : '0) | (it.cold_on ? MASK_COLD : '0);
                    trk_busy    = 1'b1;
                    trk_seq     = trk_next;
                    trk_stamp   = '0;
                    trk_retries = '0;
                    trk_next    = trk_next + 1'b1;
                    r.event_res = EV_SENT;
                end
            end
            CMD_TICK: begin
                elapsed = it.now_ms - trk_stamp;
                if (!trk_busy) begin
                    r.event_res = EV_NONE;
                end else if (trk_stamp == '0) begin
                    // zero stamp reads as unstamped, so stamping at time zero repeats
                    trk_stamp   = it.now_ms;
                    r.event_res = EV_STAMP;
                end else if (elapsed >= cfg_timeout) begin
                    if (trk_retries >= cfg_retries) begin
                        trk_busy    = 1'b0;
                        r.event_res = EV_FAILED;
                    end else begin
                        trk_retries = trk_retries + 1'b1;
                        trk_stamp   = it.now_ms;
                        r.event_res = EV_RESEND;
                    end
                end
            end
            CMD_ACK: begin
                if (!trk_busy || it.ack_seq != trk_seq) begin
                    r.event_res = EV_ACK_IGN;
                end else begin
                    trk_busy    = 1'b0;
                    r.event_res = (it.ack_status == '0) ? EV_ACK_OK : EV_ACK_ERR;
                end
            end
            default: r.event_res = EV_NONE;
        endcase
        r.seq_out  = (r.event_res == EV_ACK_IGN) ? it.ack_seq : trk_seq;
        r.retry_no = trk_retries;
        r.pending  = trk_busy;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_item mk_send(input logic hot, input logic cold);
        t_item it;
        it = '0;
        it.cmd = CMD_SEND;
        it.hot_on = hot;
        it.cold_on = cold;
        return it;
    endfunction

    function automatic t_item mk_tick(input logic [TimeW-1:0] now);
        t_item it;
        it = '0;
        it.cmd = CMD_TICK;
        it.now_ms = now;
        return it;
    endfunction

    function automatic t_item mk_ack(input logic [SeqW-1:0] seq, input logic [StatW-1:0] stat);
        t_item it;
        it = '0;
        it.cmd = CMD_ACK;
        it.ack_seq = seq;
        it.ack_status = stat;
        return it;
    endfunction

    function automatic t_result mk_res(input t_event ev, input logic [MaskW-1:0] mask,
                                       input logic [SeqW-1:0] seq,
                                       input logic [RetryW-1:0] rty, input logic pend);
        t_result r;
        r.event_res  = ev;
        r.relay_mask = mask;
        r.seq_out    = seq;
        r.retry_no   = rty;
        r.pending    = pend;
        return r;
    endfunction

    task automatic add_item(input t_item it);
        plan.push_back('{1'b0, '0, '0, it, 1'b0, '0});
    endtask

    task automatic add_typed(input t_item it, input t_result want);
        plan.push_back('{1'b0, '0, '0, it, 1'b1, want});
    endtask

    task automatic add_cfg(input logic [31:0] tmo, input logic [3:0] rty);
        plan.push_back('{1'b1, tmo, rty, '0, 1'b0, '0});
    endtask

    // Call at a rising edge; returns at the edge where the item was taken.
    task automatic offer_item(input t_item it, input logic typed, input t_result want);
        int      gap;
        t_result due;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, it.ack_status, it.ack_seq, it.now_ms, it.cold_on, it.hot_on};
        s_axis_tuser  <= it.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        due = advance_tracker(it);
        tracker_results_due.push_back(typed ? want : due);
    endtask

    // Drain, then write both registers on back-to-back edges.
    task automatic set_config(input logic [31:0] tmo, input logic [3:0] rty);
        s_axis_tvalid <= 1'b0;
        while (tracker_results_due.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_TIMEOUT;
        i_cfg_wdata <= tmo;
        @(posedge i_clk);
        i_cfg_addr  <= REG_RETRIES;
        i_cfg_wdata <= {28'd0, rty};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_timeout = tmo;
        cfg_retries = rty;
    endtask

    // Result side: random stalls plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_stalls) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.event_res  = t_event'(m_axis_tuser);
            got.relay_mask = m_axis_tdata[1:0];
            got.seq_out    = m_axis_tdata[33:2];
            got.retry_no   = m_axis_tdata[37:34];
            got.pending    = m_axis_tdata[38];
            if (tracker_results_due.size() == 0) begin
                $display("%0t: unexpected result: event %0d seq %h", $time,
                         got.event_res, got.seq_out);
                mismatch_cnt++;
            end else begin
                want = tracker_results_due.pop_front();
                if (got.event_res !== want.event_res) begin
                    $display("%0t: event_res expected %0d got %0d", $time,
                             want.event_res, got.event_res);
                    mismatch_cnt++;
                end
                if (got.relay_mask !== want.relay_mask) begin
                    $display("%0t: relay_mask expected %b got %b", $time,
                             want.relay_mask, got.relay_mask);
                    mismatch_cnt++;
                end
                if (got.seq_out !== want.seq_out) begin
                    $display("%0t: seq_out expected %h got %h", $time,
                             want.seq_out, got.seq_out);
                    mismatch_cnt++;
                end
                if (got.retry_no !== want.retry_no) begin
                    $display("%0t: retry_no expected %0d got %0d", $time,
                             want.retry_no, got.retry_no);
                    mismatch_cnt++;
                end
                if (got.pending !== want.pending) begin
                    $display("%0t: pending expected %b got %b", $time,
                             want.pending, got.pending);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("command_retry_timeout_tracker_test NOT OK");
            $finish;
        end
    end

    initial begin
        t_item  it;
        int     counted;
        int     p;

        // Defaults after reset: timeout 1000, three retries
        add_typed(mk_tick(32'd5), mk_res(EV_NONE, 2'd0, 32'd0, 4'd0, 1'b0));
        add_typed(mk_ack(32'hFFFF_FFFF, 8'hFF),
                  mk_res(EV_ACK_IGN, 2'd0, 32'hFFFF_FFFF, 4'd0, 1'b0));
        it = {CMD_SPARE, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF};
        add_typed(it, mk_res(EV_NONE, 2'd0, 32'd0, 4'd0, 1'b0));
        add_typed(mk_send(1'b1, 1'b1), mk_res(EV_SENT, 2'd3, 32'd1, 4'd0, 1'b1));
        add_typed(mk_send(1'b0, 1'b0), mk_res(EV_BUSY, 2'd0, 32'd1, 4'd0, 1'b1));
        add_typed(mk_tick(32'd0), mk_res(EV_STAMP, 2'd0, 32'd1, 4'd0, 1'b1));
        add_typed(mk_tick(32'hFFFF_FFF0), mk_res(EV_STAMP, 2'd0, 32'd1, 4'd0, 1'b1));
        // elapsed across the wrap: one short, then exactly the timeout each time
        add_item(mk_tick(32'h0000_03D7));
        add_item(mk_tick(32'h0000_03D8));
        add_item(mk_tick(32'h0000_07C0));
        add_item(mk_tick(32'h0000_0BA8));
        add_item(mk_tick(32'h0000_0F90));
        add_item(mk_ack(32'd1, 8'd0));
        add_item(mk_send(1'b1, 1'b0));
        add_item(mk_ack(32'd3, 8'd0));
        add_item(mk_ack(32'd2, 8'd0));
        add_item(mk_send(1'b0, 1'b1));
        add_item(mk_ack(32'd3, 8'h80));
        add_cfg(32'd0, 4'd0);
        add_item(mk_send(1'b0, 1'b0));
        add_item(mk_tick(32'd7));
        add_item(mk_tick(32'd7));
        add_cfg(32'hFFFF_FFFF, 4'd15);
        add_item(mk_send(1'b1, 1'b1));
        add_item(mk_tick(32'd5));
        add_item(mk_tick(32'd3));
        add_item(mk_tick(32'd4));
        add_item(mk_ack(32'd5, 8'd1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) set_config(plan[i].tmo, plan[i].rty);
            else offer_item(plan[i].it, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_config(32'd0, 4'd0);
                1: set_config(32'hFFFF_FFFF, 4'd15);
                2: set_config(TIMEOUT_RESET, RETRIES_RESET);
                default: begin
                    p = $urandom_range(0, 2);
                    set_config(p == 0 ? $urandom_range(1, 20) :
                               p == 1 ? $urandom_range(100, 5000) : $urandom(),
                               4'($urandom_range(0, 15)));
                end
            endcase
            tx_gaps   = (ph != 2) && (ph != 3);
            rx_stalls = (ph != 2);
            // back up the result side while items keep coming
            if (ph == 3) hold_req = 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                it.hot_on     = 1'($urandom_range(0, 1));
                it.cold_on    = 1'($urandom_range(0, 1));
                it.now_ms     = $urandom();
                it.ack_seq    = $urandom();
                it.ack_status = 8'($urandom_range(0, 255));
                p = $urandom_range(0, 99);
                if (p < 4) begin
                    it.cmd = CMD_SPARE;
                end else if (!trk_busy) begin
                    it.cmd = (p < 80) ? CMD_SEND : (p < 90) ? CMD_TICK : CMD_ACK;
                end else begin
                    it.cmd = (p < 10) ? CMD_SEND : (p < 78) ? CMD_TICK : CMD_ACK;
                end
                if (it.cmd == CMD_TICK) begin
                    // advance wall time, mostly landing on or near the timeout
                    p = $urandom_range(0, 99);
                    if (p < 35) wall_ms = wall_ms + cfg_timeout;
                    else if (p < 45) wall_ms = wall_ms + cfg_timeout - 1'b1;
                    else if (p < 75) wall_ms = wall_ms + $urandom_range(0, 3);
                    else if (p < 80) wall_ms = '0;
                    else if (p < 90) wall_ms = $urandom();
                    else wall_ms = wall_ms + cfg_timeout + $urandom_range(1, 50);
                    it.now_ms = wall_ms;
                end else if (it.cmd == CMD_ACK) begin
                    p = $urandom_range(0, 99);
                    if (p < 70) it.ack_seq = trk_seq;
                    else if (p < 78) it.ack_seq = trk_seq + 1'b1;
                    else if (p < 85) it.ack_seq = trk_seq - 1'b1;
                    if ($urandom_range(0, 1)) it.ack_status = '0;
                end
                offer_item(it, 1'b0, '0);
                counted++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (tracker_results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("command_retry_timeout_tracker_test OK");
        end else begin
            $display("command_retry_timeout_tracker_test NOT OK");
        end
        $finish;
    end

endmodule
